### src/csrs_pkg.sv
// Package for the chirp spectrum row synthesizer: codes, widths, ROM builders.
`default_nettype none

package csrs_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned PIX_W    = 9;
    localparam int unsigned SAMPLE_W = 18;
    localparam int unsigned TWID_W   = 16;   // Q1.15
    localparam int unsigned CHIRP_W  = 20;   // Q8, fits the largest amplitude
    localparam int unsigned ROUND_SH = 23;   // Q8 * Q15 -> integer

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 18'h1FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 18'h20000;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [63:0] AMP_BASE = 64'd1536000;

    typedef logic [2*TWID_W-1:0]  twid_pair_t;   // {cos, sin}
    typedef logic [2*CHIRP_W-1:0] chirp_pair_t;  // {re, im}

    // floor square root, one bit per step
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= v)
                res = cand;
        end
        return res;
    endfunction

    // Q30 -> Q15, round half up, clamp at +1
    function automatic logic signed [TWID_W-1:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return TWID_W'(r);
    endfunction

    // cos/sin in Q1.15 of a turn given in Q32
    function automatic twid_pair_t trig_q15(input logic [63:0] t);
        logic [1:0]  q;
        logic [63:0] r;
        logic        neg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] c;
        logic signed [TWID_W-1:0] cq;
        logic signed [TWID_W-1:0] sv;
        logic signed [TWID_W-1:0] sq;
        logic signed [TWID_W-1:0] co;
        logic signed [TWID_W-1:0] si;
        q   = t[31:30];
        r   = t & (ONE_Q30 - 64'd1);
        neg = 1'b0;
        if (r >= (64'd1 << 29)) begin
            r   = ONE_Q30 - r;
            neg = 1'b1;
            q   = q + 2'd1;
        end
        x  = (r * PI_Q30) >> 31;
        x2 = (x * x) >> 30;
        term = x;
        s    = x;
        term = ((term * x2) >> 30) / 64'd6;   s = s - term;
        term = ((term * x2) >> 30) / 64'd20;  s = s + term;
        term = ((term * x2) >> 30) / 64'd42;  s = s - term;
        term = ((term * x2) >> 30) / 64'd72;  s = s + term;
        term = ONE_Q30;
        c    = ONE_Q30;
        term = ((term * x2) >> 30) / 64'd2;   c = c - term;
        term = ((term * x2) >> 30) / 64'd12;  c = c + term;
        term = ((term * x2) >> 30) / 64'd30;  c = c - term;
        term = ((term * x2) >> 30) / 64'd56;  c = c + term;
        term = ((term * x2) >> 30) / 64'd90;  c = c - term;
        cq = to_q15(c);
        sv = to_q15(s);
        sq = neg ? -sv : sv;
        unique case (q)
            2'd0:    begin co = cq;  si = sq;  end
            2'd1:    begin co = -sq; si = cq;  end
            2'd2:    begin co = -cq; si = -sq; end
            default: begin co = sq;  si = -cq; end
        endcase
        return {co, si};
    endfunction

    // Q8 amplitude times Q15 value, round half away from zero back to Q8
    function automatic logic signed [CHIRP_W-1:0] scale_q8(input logic [63:0] amp,
                                                           input logic signed [TWID_W-1:0] v);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = signed'(amp) * 64'(v);
        if (p >= 0)
            r = (p + 64'sd16384) >>> 15;
        else
            r = -((-p + 64'sd16384) >>> 15);
        return CHIRP_W'(r);
    endfunction

    function automatic chirp_pair_t chirp_entry(input logic [63:0] amp,
                                                input logic [63:0] t);
        twid_pair_t tp;
        tp = trig_q15(t);
        return {scale_q8(amp, tp[2*TWID_W-1:TWID_W]), scale_q8(amp, tp[TWID_W-1:0])};
    endfunction

endpackage

`default_nettype wire

### src/chirp_spectrum_row_synth.sv
// Top level: one-row spectrogram text synthesizer with a shared complex MAC.
`default_nettype none

// Holds one image row of ROW_WIDTH on/off bits; column i drives bin
// (START_BIN + i) mod FFT_LEN with a fixed quadratic-phase chirp weight.
// Each item returns exactly one result. A pixel write (func 0), an unknown
// code or a sample request all return one transfer; only func 1 carries a
// nonzero sample. A sample request walks every column once through a single
// complex multiply-accumulate unit (one column per cycle). A clear (func 2)
// sweeps the row memory, one bit per cycle. After reset the same clearing
// pass runs before in_ready first rises. The block takes one item at a time;
// a finished result waits in the output register, so the next item is taken
// while the previous result is still pending. Twiddle and chirp tables are
// ROMs built at elaboration; the row bits live in a 1-bit RAM.
module chirp_spectrum_row_synth
    import csrs_pkg::*;
#(
    parameter int unsigned FFT_LEN   = 2048,
    parameter int unsigned ROW_WIDTH = 392,
    parameter int unsigned START_BIN = 51
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [FUNC_W-1:0]          func,
    input  wire logic [PIX_W-1:0]           pixel_index,
    input  wire logic                       pixel_on,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      sample,
    output logic                            buffer_end
);

    localparam int unsigned POS_W  = $clog2(FFT_LEN);
    localparam int unsigned RW_AW  = $clog2(ROW_WIDTH);
    localparam int unsigned PROD_W = CHIRP_W + TWID_W;
    localparam int unsigned ACC_W  = PROD_W + RW_AW + 2;
    localparam int unsigned SB_MOD = START_BIN % FFT_LEN;
    localparam logic [63:0] W2     = 64'(2 * ROW_WIDTH);
    localparam logic [63:0] AMP_Q8 =
        (isqrt64((64'd4 * AMP_BASE * AMP_BASE) / 64'(ROW_WIDTH)) + 64'd1) >> 1;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;   // clearing pass over the row RAM
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;   // one column per cycle
    localparam logic [2:0] S_ROUND = 3'd3;   // magnitude of the sum
    localparam logic [2:0] S_SAT   = 3'd4;   // round and saturate
    localparam logic [2:0] S_DONE  = 3'd5;   // hand result to output register

    // ------------------------------------------------------------------
    // ROMs, built at elaboration
    // ------------------------------------------------------------------
    twid_pair_t  twid_rom  [FFT_LEN];
    chirp_pair_t chirp_rom [ROW_WIDTH];

    for (genvar g = 0; g < FFT_LEN; g++) begin : g_twid
        localparam logic [63:0] TURN = (64'(g) << 32) / 64'(FFT_LEN);
        assign twid_rom[g] = trig_q15(TURN);
    end

    // weight of column i is the turn -(i*i mod 2W)/(2W)
    for (genvar g = 0; g < ROW_WIDTH; g++) begin : g_chirp
        localparam logic [63:0] PH   = (64'(g) * 64'(g)) % W2;
        localparam logic [63:0] P    = (W2 - PH) % W2;
        localparam logic [63:0] TURN = (P << 32) / W2;
        assign chirp_rom[g] = chirp_entry(AMP_Q8, TURN);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                 state_reg,   state_next;
    logic [RW_AW-1:0]           clr_reg,     clr_next;
    logic                       reply_reg,   reply_next;     // clear answers
    logic [POS_W-1:0]           pos_reg,     pos_next;
    logic [POS_W-1:0]           base_reg,    base_next;      // START_BIN*n mod N
    logic [POS_W-1:0]           n_reg,       n_next;
    logic [POS_W-1:0]           m_reg,       m_next;         // k*n mod N
    logic [RW_AW-1:0]           idx_reg,     idx_next;
    logic                       issue_reg,   issue_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s2_valid_reg, s2_valid_next;
    logic signed [ACC_W-1:0]    acc_reg,     acc_next;
    logic                       neg_reg,     neg_next;
    logic [ACC_W-1:0]           mag_reg,     mag_next;
    logic signed [SAMPLE_W-1:0] res_reg,     res_next;
    logic                       end_reg,     end_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg,  sample_next;
    logic                       buf_end_reg, buf_end_next;

    // datapath registers, no reset
    logic                       row_q_reg;
    twid_pair_t                 twid_q_reg;
    chirp_pair_t                chirp_q_reg;
    logic signed [PROD_W-1:0]   prod_re_reg, prod_re_next;
    logic signed [PROD_W-1:0]   prod_im_reg, prod_im_next;

    // row RAM
    logic                       row_mem [ROW_WIDTH];
    logic                       mem_we;
    logic [RW_AW-1:0]           mem_wa;
    logic                       mem_wd;

    logic                       in_xfer;
    logic                       out_free;
    logic signed [CHIRP_W-1:0]  cr_w, ci_w;
    logic signed [TWID_W-1:0]   tc_w, ts_w;
    logic [POS_W:0]             m_sum;
    logic [POS_W:0]             b_sum;
    logic [ACC_W-1:0]           rnd_w;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign buffer_end = buf_end_reg;

    assign cr_w = signed'(chirp_q_reg[2*CHIRP_W-1:CHIRP_W]);
    assign ci_w = signed'(chirp_q_reg[CHIRP_W-1:0]);
    assign tc_w = signed'(twid_q_reg[2*TWID_W-1:TWID_W]);
    assign ts_w = signed'(twid_q_reg[TWID_W-1:0]);

    // twiddle index steps by n per column, base steps by START_BIN per sample
    assign m_sum = {1'b0, m_reg} + {1'b0, n_reg};
    assign b_sum = {1'b0, base_reg} + (POS_W+1)'(SB_MOD);
    assign rnd_w = mag_reg + (ACC_W'(1) << (ROUND_SH - 1));

    // ------------------------------------------------------------------
    // Row RAM write port: clearing pass or pixel write
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (in_xfer && func == FUNC_WRITE && 32'(pixel_index) < ROW_WIDTH)
        begin
            mem_we = 1'b1;
            mem_wa = RW_AW'(pixel_index);
            mem_wd = pixel_on;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_wa] <= mem_wd;
    end

    // registered reads of RAM and ROMs
    always_ff @(posedge clk)
    begin
        row_q_reg   <= row_mem[idx_reg];
        twid_q_reg  <= twid_rom[m_reg];
        chirp_q_reg <= chirp_rom[idx_reg];
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
    end

    // ------------------------------------------------------------------
    // Sequencer and MAC
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        reply_next     = reply_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        s1_valid_next  = issue_reg;
        s2_valid_next  = s1_valid_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        res_next       = res_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sample_next    = sample_reg;
        buf_end_next   = buf_end_reg;

        // products of lit columns only
        prod_re_next = row_q_reg ? PROD_W'(cr_w) * PROD_W'(tc_w) : '0;
        prod_im_next = row_q_reg ? PROD_W'(ci_w) * PROD_W'(ts_w) : '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + RW_AW'(1);
                if (32'(clr_reg) == ROW_WIDTH - 1)
                begin
                    clr_next   = '0;
                    reply_next = 1'b0;
                    state_next = reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next = '0;
                    end_next = 1'b0;
                    priority if (func == FUNC_SAMPLE)
                    begin
                        end_next   = (32'(pos_reg) == FFT_LEN - 1);
                        pos_next   = (32'(pos_reg) == FFT_LEN - 1) ? '0 : pos_reg + POS_W'(1);
                        base_next  = (32'(b_sum) >= FFT_LEN) ?
                                     POS_W'(b_sum - (POS_W+1)'(FFT_LEN)) : POS_W'(b_sum);
                        n_next     = pos_reg;
                        m_next     = base_reg;
                        idx_next   = '0;
                        issue_next = 1'b1;
                        acc_next   = '0;
                        state_next = S_MAC;
                    end
                    else if (func == FUNC_CLEAR)
                    begin
                        pos_next   = '0;
                        base_next  = '0;
                        clr_next   = '0;
                        reply_next = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MAC:
            begin
                if (issue_reg)
                begin
                    idx_next = idx_reg + RW_AW'(1);
                    m_next   = (32'(m_sum) >= FFT_LEN) ?
                               POS_W'(m_sum - (POS_W+1)'(FFT_LEN)) : POS_W'(m_sum);
                    if (32'(idx_reg) == ROW_WIDTH - 1)
                        issue_next = 1'b0;
                end
                if (s2_valid_reg)
                    acc_next = acc_reg + ACC_W'(prod_re_reg) - ACC_W'(prod_im_reg);
                if (!issue_reg && !s1_valid_reg && !s2_valid_reg)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                neg_next   = acc_reg[ACC_W-1];
                mag_next   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                // round half away from zero, then clamp to the sample range
                priority if (!neg_reg && (rnd_w >> ROUND_SH) > ACC_W'(SAMPLE_MAX))
                    res_next = SAMPLE_MAX;
                else if (neg_reg && (rnd_w >> ROUND_SH) > ACC_W'(SAMPLE_MAX) + ACC_W'(1))
                    res_next = SAMPLE_MIN;
                else if (neg_reg)
                    res_next = -SAMPLE_W'(rnd_w >> ROUND_SH);
                else
                    res_next = SAMPLE_W'(rnd_w >> ROUND_SH);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = res_reg;
                    buf_end_next   = end_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            reply_reg     <= 1'b0;
            pos_reg       <= '0;
            base_reg      <= '0;
            issue_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            reply_reg     <= reply_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            issue_reg     <= issue_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        m_reg       <= m_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        res_reg     <= res_next;
        end_reg     <= end_next;
        sample_reg  <= sample_next;
        buf_end_reg <= buf_end_next;
    end

`ifndef NO_ASSERTIONS
    // a sample request starts the column walk on the next cycle
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && func == FUNC_SAMPLE) |=> (state_reg == S_MAC && issue_reg))
        else $error("sample request did not start the MAC walk");

    // the MAC pipeline is empty whenever the sum is taken for rounding
    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (!issue_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("rounding started with products still in flight");

    // products only flow while walking the row
    a_pipe_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == S_MAC))
        else $error("MAC pipeline active outside the walk");

    // a completed item always lands in the output register
    a_done_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result was not presented");

    // modular indices stay inside the buffer
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(pos_reg) < FFT_LEN) && (32'(base_reg) < FFT_LEN))
        else $error("buffer position out of range");
`endif

endmodule

`default_nettype wire
